FILE: src/totp_code_generator_macros.svh
// ----------------------------------------------------------------------------
// TOTP code generator assertion macros
// Shared forms for the concurrent checks of the generator.
// ----------------------------------------------------------------------------
`ifndef TOTP_CODE_GENERATOR_MACROS_SVH
`define TOTP_CODE_GENERATOR_MACROS_SVH

// same-cycle implication under asynchronous active-low reset
`define TOTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("totp check failed");

// next-cycle implication under asynchronous active-low reset
`define TOTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("totp check failed");

`endif

FILE: src/totp_pkg.sv
// ----------------------------------------------------------------------------
// TOTP package
// Types, constants and helpers shared by the generator and its round unit.
// ----------------------------------------------------------------------------
`default_nettype none

package totp_pkg;

	localparam int MAX_KEY_BYTES_DEF = 20;
	localparam int STORED_KEY_BYTES  = 20;

	localparam logic [2:0] REG_KEY0   = 3'd0;
	localparam logic [2:0] REG_KEY1   = 3'd1;
	localparam logic [2:0] REG_KEY2   = 3'd2;
	localparam logic [2:0] REG_KLEN   = 3'd3;
	localparam logic [2:0] REG_STEP   = 3'd4;
	localparam logic [2:0] REG_DIGITS = 3'd5;

	localparam logic [30:0] STEP_RESET   = 31'd30;
	localparam logic [3:0]  DIGITS_RESET = 4'd6;
	localparam logic [3:0]  DIGITS_MIN   = 4'd6;
	localparam logic [3:0]  DIGITS_MAX   = 4'd8;

	localparam logic [30:0] MOD_6 = 31'd1000000;
	localparam logic [30:0] MOD_7 = 31'd10000000;
	localparam logic [30:0] MOD_8 = 31'd100000000;

	localparam logic [7:0] IPAD = 8'h36;
	localparam logic [7:0] OPAD = 8'h5c;

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	localparam logic [63:0] INNER_BITS = 64'd576;
	localparam logic [63:0] OUTER_BITS = 64'd672;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} sha_state_t;

	localparam sha_state_t SHA_IV = '{
		a: 32'h67452301, b: 32'hefcdab89, c: 32'h98badcfe,
		d: 32'h10325476, e: 32'hc3d2e1f0
	};

	// key padded to one block and xored with the pad byte
	function automatic logic [511:0] key_block(input logic [159:0] key,
		input logic [6:0] klen, input logic [7:0] pad);
		logic [511:0] blk;
		logic [7:0]   kb;
		blk = '0;
		for (int i = 0; i < 64; i++) begin
			kb = 8'd0;
			if (i < STORED_KEY_BYTES && 7'(i) < klen)
				kb = key[159 - 8 * i -: 8];
			blk[511 - 8 * i -: 8] = kb ^ pad;
		end
		return blk;
	endfunction

endpackage

`default_nettype wire

FILE: src/totp_code_generator.sv
// ----------------------------------------------------------------------------
// TOTP code generator
// Time-step counter, HMAC-SHA1 of the counter and dynamic truncation to a
// six to eight digit code, all on one shared divider and one SHA-1 round.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+----------------------------------
//  in       | in        | in_valid/in_stall | unix_seconds
//  out      | out       | out_valid/out_stall| otp_code, step_counter, seconds_left
//  cfg      | in        | cfg_we            | cfg_index, cfg_data
//
//  Each word passes through 63 divide steps for the counter, four SHA-1
//  blocks of one load, 80 rounds and one add each, one truncation step,
//  63 divide steps for the modulo and a hand-off state, all serial on
//  the single round unit and the bit-serial divider.
//  Reset clears the sequencer, the output valid and the registers to
//  their defaults (step 30 s, 6 digits, empty key).
//  in_stall is high while a word is in work; a finished word waits for a
//  stalled output register before the next input word is taken.
//
`default_nettype none

module totp_code_generator #(
	parameter int MAX_KEY_BYTES = totp_pkg::MAX_KEY_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [62:0] unix_seconds,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [26:0]      otp_code,
	output logic [62:0]      step_counter,
	output logic [30:0]      seconds_left
);

`include "totp_code_generator_macros.svh"

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DIV   = 8'b0000_0010,
		S_LOAD  = 8'b0000_0100,
		S_ROUND = 8'b0000_1000,
		S_ADD   = 8'b0001_0000,
		S_TRUNC = 8'b0010_0000,
		S_MOD   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	// configuration registers
	logic [63:0] key0_q, key1_q;
	logic [31:0] key2_q;
	logic [4:0]  klen_q;
	logic [30:0] step_q;
	logic [3:0]  digits_q;

	state_t      state_q;
	logic [5:0]  div_cnt_q;
	logic [6:0]  rnd_q;
	logic [1:0]  phase_q;

	// shared divider
	logic [62:0] div_num_q;
	logic [30:0] div_rem_q;
	logic [30:0] div_den_q;
	logic [31:0] div_r2;
	logic        div_ge;
	logic [30:0] div_rem_n;
	logic [62:0] div_num_n;

	// hash datapath
	totp_pkg::sha_state_t h_q, work_q, work_n, h_sum;
	logic [31:0]  w_q [16];
	logic [31:0]  w_new;
	logic [159:0] inner_q;
	logic [62:0]  ctr_q;
	logic [30:0]  left_q;
	logic [511:0] blk;
	logic [159:0] key_all;
	logic [6:0]   klen_eff;
	logic [159:0] digest;
	logic [3:0]   offset;
	logic [31:0]  bin;
	logic [3:0]   digits_eff;
	logic [30:0]  modv;

	// output register
	logic         out_valid_q;
	logic [26:0]  code_q;
	logic [62:0]  ctr_out_q;
	logic [30:0]  left_out_q;
	logic [26:0]  code_q_n_hold;

	logic in_acc;
	logic out_load;

	assign in_stall     = (state_q != S_IDLE);
	assign in_acc       = in_valid && !in_stall;
	assign out_valid    = out_valid_q;
	assign otp_code     = code_q;
	assign step_counter = ctr_out_q;
	assign seconds_left = left_out_q;
	assign out_load     = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// configuration writes; unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q   <= '0;
			key1_q   <= '0;
			key2_q   <= '0;
			klen_q   <= '0;
			step_q   <= totp_pkg::STEP_RESET;
			digits_q <= totp_pkg::DIGITS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				totp_pkg::REG_KEY0:   key0_q   <= cfg_data;
				totp_pkg::REG_KEY1:   key1_q   <= cfg_data;
				totp_pkg::REG_KEY2:   key2_q   <= cfg_data[31:0];
				totp_pkg::REG_KLEN:   klen_q   <= cfg_data[4:0];
				totp_pkg::REG_STEP:   step_q   <= cfg_data[30:0];
				totp_pkg::REG_DIGITS: digits_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// restoring divide step: shift one dividend bit into the remainder
	always_comb begin
		div_r2    = {div_rem_q, div_num_q[62]};
		div_ge    = (div_r2 >= {1'b0, div_den_q});
		div_rem_n = div_ge ? 31'(div_r2 - {1'b0, div_den_q}) : div_r2[30:0];
		div_num_n = {div_num_q[61:0], div_ge};
	end

	// key length clipped to the configured maximum
	always_comb begin
		key_all  = {key0_q, key1_q, key2_q};
		klen_eff = (int'(klen_q) > MAX_KEY_BYTES) ? 7'(MAX_KEY_BYTES) : {2'b00, klen_q};
	end

	// message block for each of the four compressions
	always_comb begin
		case (phase_q)
			2'd0:    blk = totp_pkg::key_block(key_all, klen_eff, totp_pkg::IPAD);
			2'd1:    blk = {1'b0, ctr_q, 32'h8000_0000, 352'd0, totp_pkg::INNER_BITS};
			2'd2:    blk = totp_pkg::key_block(key_all, klen_eff, totp_pkg::OPAD);
			default: blk = {inner_q, 32'h8000_0000, 256'd0, totp_pkg::OUTER_BITS};
		endcase
	end

	totp_round u_round (
		.st  (work_q),
		.w   (w_q[0]),
		.rnd (rnd_q),
		.nxt (work_n)
	);

	always_comb begin
		w_new   = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new   = {w_new[30:0], w_new[31]};
		h_sum.a = h_q.a + work_q.a;
		h_sum.b = h_q.b + work_q.b;
		h_sum.c = h_q.c + work_q.c;
		h_sum.d = h_q.d + work_q.d;
		h_sum.e = h_q.e + work_q.e;
	end

	// dynamic truncation and the code modulus
	always_comb begin
		digest = h_q;
		offset = h_q.e[3:0];
		bin    = digest[8'd159 - {1'b0, offset, 3'b000} -: 32];
		if (digits_q < totp_pkg::DIGITS_MIN)
			digits_eff = totp_pkg::DIGITS_MIN;
		else if (digits_q > totp_pkg::DIGITS_MAX)
			digits_eff = totp_pkg::DIGITS_MAX;
		else
			digits_eff = digits_q;
		case (digits_eff)
			4'd6:    modv = totp_pkg::MOD_6;
			4'd7:    modv = totp_pkg::MOD_7;
			default: modv = totp_pkg::MOD_8;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
			rnd_q     <= '0;
			phase_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q   <= S_DIV;
						div_cnt_q <= '0;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd62) begin
						state_q <= S_LOAD;
						phase_q <= 2'd0;
					end
				end
				S_LOAD: begin
					state_q <= S_ROUND;
					rnd_q   <= '0;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79)
						state_q <= S_ADD;
				end
				S_ADD: begin
					if (phase_q == 2'd3) begin
						state_q <= S_TRUNC;
					end else begin
						state_q <= S_LOAD;
						phase_q <= phase_q + 2'd1;
					end
				end
				S_TRUNC: begin
					state_q   <= S_MOD;
					div_cnt_q <= '0;
				end
				S_MOD: begin
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd62)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				// zero step acts as one second
				div_num_q <= unix_seconds;
				div_rem_q <= '0;
				div_den_q <= (step_q == 31'd0) ? 31'd1 : step_q;
			end
			S_DIV, S_MOD: begin
				div_num_q <= div_num_n;
				div_rem_q <= div_rem_n;
				if (state_q == S_DIV && div_cnt_q == 6'd62) begin
					ctr_q  <= div_num_n;
					left_q <= div_den_q - div_rem_n;
					h_q    <= totp_pkg::SHA_IV;
				end
				if (state_q == S_MOD && div_cnt_q == 6'd62)
					code_q_n_hold <= div_rem_n[26:0];
			end
			S_LOAD: begin
				for (int j = 0; j < 16; j++)
					w_q[j] <= blk[511 - 32 * j -: 32];
				work_q <= h_q;
			end
			S_ROUND: begin
				work_q <= work_n;
				for (int j = 0; j < 15; j++)
					w_q[j] <= w_q[j + 1];
				w_q[15] <= w_new;
			end
			S_ADD: begin
				// inner digest done: keep it and restart for the outer hash
				if (phase_q == 2'd1) begin
					inner_q <= h_sum;
					h_q     <= totp_pkg::SHA_IV;
				end else begin
					h_q <= h_sum;
				end
			end
			S_TRUNC: begin
				div_num_q <= {32'd0, bin[30:0]};
				div_rem_q <= '0;
				div_den_q <= modv;
			end
			default: ;
		endcase
	end

	// output register: hold while stalled, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			code_q     <= code_q_n_hold;
			ctr_out_q  <= ctr_q;
			left_out_q <= left_q;
		end
	end

	`TOTP_ASSERT_NEXT(a_accept_starts_div, clk, arst_n, in_acc, state_q == S_DIV)
	`TOTP_ASSERT_NOW(a_rem_below_den, clk, arst_n,
		(state_q == S_DIV) || (state_q == S_MOD), div_rem_q < div_den_q)
	`TOTP_ASSERT_NOW(a_round_range, clk, arst_n, state_q == S_ROUND, rnd_q < 7'd80)

endmodule

`default_nettype wire

FILE: src/totp_round.sv
// ----------------------------------------------------------------------------
// TOTP SHA-1 round
// One SHA-1 compression round, reused for all eighty rounds of each block.
// ----------------------------------------------------------------------------
`default_nettype none

module totp_round (
	input  totp_pkg::sha_state_t st,
	input  logic [31:0]          w,
	input  logic [6:0]           rnd,
	output totp_pkg::sha_state_t nxt
);

	logic [31:0] f;
	logic [31:0] k;

	always_comb begin
		if (rnd < 7'd20) begin
			f = (st.b & st.c) | (~st.b & st.d);
			k = totp_pkg::K0;
		end else if (rnd < 7'd40) begin
			f = st.b ^ st.c ^ st.d;
			k = totp_pkg::K1;
		end else if (rnd < 7'd60) begin
			f = (st.b & st.c) | (st.b & st.d) | (st.c & st.d);
			k = totp_pkg::K2;
		end else begin
			f = st.b ^ st.c ^ st.d;
			k = totp_pkg::K3;
		end
	end

	always_comb begin
		nxt.a = {st.a[26:0], st.a[31:27]} + f + st.e + k + w;
		nxt.b = st.a;
		nxt.c = {st.b[1:0], st.b[31:2]};
		nxt.d = st.c;
		nxt.e = st.d;
	end

endmodule

`default_nettype wire
